>>> hw/rtl/rgc_pkg.sv
package rgc_pkg;

  localparam int MAX_POINTS_DEF = 8;
  localparam int COORD_BITS_DEF = 12;

  localparam int SIZE_W = 13;
  localparam int Q16_W  = 17;
  localparam logic [Q16_W-1:0] ONE_Q16 = 17'h10000;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_COUNT  = 2'd2
  } reg_idx_t;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  typedef struct packed {
    logic             func;
    logic [2:0]       idx;
    logic [Q16_W-1:0] ptime;
    logic [Q16_W-1:0] pval;
  } item_sb_t;

endpackage

>>> hw/rtl/rgc_pdiv.sv
module rgc_pdiv #(
  parameter int DEN_W = 13,
  parameter int Q_W   = 16,
  parameter int SPS   = 4,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [DEN_W-1:0] in_rem,
  input  logic [Q_W-1:0]   in_bits,
  input  logic [DEN_W-1:0] in_den,
  input  logic [SB_W-1:0]  in_sb,
  output logic             out_vld,
  output logic [Q_W-1:0]   out_quo,
  output logic [SB_W-1:0]  out_sb
);

  localparam int NST = (Q_W + SPS - 1) / SPS;

  logic             st_vld  [NST+1];
  logic [DEN_W-1:0] st_rem  [NST+1];
  logic [Q_W-1:0]   st_quo  [NST+1];
  logic [Q_W-1:0]   st_bits [NST+1];
  logic [DEN_W-1:0] st_den  [NST+1];
  logic [SB_W-1:0]  st_sb   [NST+1];

  assign st_vld[0]  = in_vld;
  assign st_rem[0]  = in_rem;
  assign st_quo[0]  = '0;
  assign st_bits[0] = in_bits;
  assign st_den[0]  = in_den;
  assign st_sb[0]   = in_sb;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic             vld_r;
    logic [DEN_W-1:0] rem_r, rem_nxt;
    logic [Q_W-1:0]   quo_r, quo_nxt;
    logic [Q_W-1:0]   bits_r, bits_nxt;
    logic [DEN_W-1:0] den_r;
    logic [SB_W-1:0]  sb_r;

    always_comb begin : p_step
      logic [DEN_W:0] tr;
      rem_nxt  = st_rem[s];
      quo_nxt  = st_quo[s];
      bits_nxt = st_bits[s];
      for (int k = 0; k < SPS; k++) begin
        if (s * SPS + k < Q_W) begin
          tr = {rem_nxt, bits_nxt[Q_W-1]};
          bits_nxt = bits_nxt << 1;
          if (tr >= {1'b0, st_den[s]}) begin
            tr = tr - {1'b0, st_den[s]};
            quo_nxt = {quo_nxt[Q_W-2:0], 1'b1};
          end else begin
            quo_nxt = {quo_nxt[Q_W-2:0], 1'b0};
          end
          rem_nxt = tr[DEN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= st_vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_nxt;
        quo_r  <= quo_nxt;
        bits_r <= bits_nxt;
        den_r  <= st_den[s];
        sb_r   <= st_sb[s];
      end
    end

    assign st_vld[s+1]  = vld_r;
    assign st_rem[s+1]  = rem_r;
    assign st_quo[s+1]  = quo_r;
    assign st_bits[s+1] = bits_r;
    assign st_den[s+1]  = den_r;
    assign st_sb[s+1]   = sb_r;
  end

  assign out_vld = st_vld[NST];
  assign out_quo = st_quo[NST];
  assign out_sb  = st_sb[NST];

endmodule

>>> hw/rtl/radial_gradient_curve_pixel_unit.sv
// channel  | handshake         | payload
// in       | in_valid/in_stall | func, point_index, point_time, point_value, pixel_x, pixel_y
// out      | out_valid/out_stall | gray_level
// cfg      | APB psel/penable  | width, height, point count at 0x0, 0x4, 0x8
//
// One item per cycle unless a valid output is stalled; registers from accept to out_valid:
// 4 divide, 2 square/add, 4 root, 1 t, 1 curve, 2 product/sum, 5 divide, 1 output.
// Load items write the curve when they reach the curve stage and give no result.
// A stalled valid output freezes the whole pipeline; in_stall = out_stall && out_valid.
// Sync active-low reset clears valids, sets width/height/count 64/64/2; curve not written.
module radial_gradient_curve_pixel_unit #(
  parameter int MAX_POINTS = rgc_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = rgc_pkg::COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_func,
  input  logic [2:0]             in_point_index,
  input  logic [rgc_pkg::Q16_W-1:0] in_point_time,
  input  logic [rgc_pkg::Q16_W-1:0] in_point_value,
  input  logic [COORD_BITS-1:0]  in_pixel_x,
  input  logic [COORD_BITS-1:0]  in_pixel_y,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_gray_level,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import rgc_pkg::*;

  localparam int NUM_W = (COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 2 : SIZE_W + 1;
  localparam int SQ_NST = 4;
  localparam int SQ_SPS = 4;

  // configuration
  logic [SIZE_W-1:0] width_r, height_r;
  logic [3:0]        pcount_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(64);
      height_r <= SIZE_W'(64);
      pcount_r <= 4'd2;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_WIDTH:  width_r  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: height_r <= pwdata[SIZE_W-1:0];
        REG_COUNT:  pcount_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_WIDTH:  prdata = 32'(width_r);
      REG_HEIGHT: prdata = 32'(height_r);
      REG_COUNT:  prdata = 32'(pcount_r);
      default:    prdata = '0;
    endcase
  end

  logic en;
  logic out_vld_r;
  logic [7:0] out_gray_r;

  assign en       = !out_vld_r || !out_stall;
  assign in_stall = !en;

  // normalized distance numerators
  logic [NUM_W-1:0]  twx, twy, szx, szy, numx, numy;
  logic              satx, saty;
  logic [SIZE_W-1:0] remx, remy;
  item_sb_t          in_sb;

  always_comb begin
    twx  = NUM_W'({in_pixel_x, 1'b0});
    twy  = NUM_W'({in_pixel_y, 1'b0});
    szx  = NUM_W'(width_r);
    szy  = NUM_W'(height_r);
    numx = (szx >= twx) ? szx - twx : twx - szx;
    numy = (szy >= twy) ? szy - twy : twy - szy;
    satx = numx >= szx;
    saty = numy >= szy;
    remx = satx ? '0 : numx[SIZE_W-1:0];
    remy = saty ? '0 : numy[SIZE_W-1:0];
    in_sb.func  = in_func;
    in_sb.idx   = in_point_index;
    in_sb.ptime = in_point_time;
    in_sb.pval  = in_point_value;
  end

  logic                      dx_vld, dy_vld;
  logic [15:0]               qx, qy;
  logic [$bits(item_sb_t):0] dx_sb;
  logic                      dy_sb;

  rgc_pdiv #(.DEN_W(SIZE_W), .Q_W(16), .SPS(4), .SB_W($bits(item_sb_t) + 1)) u_divx (
    .clk, .rst_n, .en,
    .in_vld(in_valid), .in_rem(remx), .in_bits(16'd0), .in_den(width_r),
    .in_sb({satx, in_sb}),
    .out_vld(dx_vld), .out_quo(qx), .out_sb(dx_sb)
  );

  rgc_pdiv #(.DEN_W(SIZE_W), .Q_W(16), .SPS(4), .SB_W(1)) u_divy (
    .clk, .rst_n, .en,
    .in_vld(in_valid), .in_rem(remy), .in_bits(16'd0), .in_den(height_r),
    .in_sb(saty),
    .out_vld(dy_vld), .out_quo(qy), .out_sb(dy_sb)
  );

  // squares
  logic [Q16_W-1:0] dx_nxt, dy_nxt;
  logic             m_vld_r;
  logic [33:0]      sqx_r, sqy_r;
  item_sb_t         m_sb_r;

  assign dx_nxt = dx_sb[$bits(item_sb_t)] ? ONE_Q16 : {1'b0, qx};
  assign dy_nxt = dy_sb ? ONE_Q16 : {1'b0, qy};

  // sum
  logic        a_vld_r;
  logic [34:0] sum_r;
  item_sb_t    a_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      a_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= dx_vld;
      a_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r  <= 34'(dx_nxt) * 34'(dx_nxt);
      sqy_r  <= 34'(dy_nxt) * 34'(dy_nxt);
      m_sb_r <= item_sb_t'(dx_sb[$bits(item_sb_t)-1:0]);
      sum_r  <= 35'(sqx_r) + 35'(sqy_r);
      a_sb_r <= m_sb_r;
    end
  end

  // integer square root, two bits of input per step
  logic        sq_vld [SQ_NST+1];
  logic        sq_sat [SQ_NST+1];
  logic [17:0] sq_rem [SQ_NST+1];
  logic [15:0] sq_res [SQ_NST+1];
  logic [31:0] sq_val [SQ_NST+1];
  item_sb_t    sq_sb  [SQ_NST+1];

  assign sq_vld[0] = a_vld_r;
  assign sq_sat[0] = sum_r[34:32] != 3'd0;
  assign sq_rem[0] = '0;
  assign sq_res[0] = '0;
  assign sq_val[0] = sum_r[31:0];
  assign sq_sb[0]  = a_sb_r;

  for (genvar s = 0; s < SQ_NST; s++) begin : g_sqrt
    logic        vld_r, sat_r;
    logic [17:0] rem_r, rem_nxt;
    logic [15:0] res_r, res_nxt;
    logic [31:0] val_r, val_nxt;
    item_sb_t    sb_r;

    always_comb begin : p_step
      logic [19:0] r2;
      logic [19:0] trial;
      rem_nxt = sq_rem[s];
      res_nxt = sq_res[s];
      val_nxt = sq_val[s];
      for (int k = 0; k < SQ_SPS; k++) begin
        r2      = {rem_nxt, val_nxt[31:30]};
        val_nxt = val_nxt << 2;
        trial   = {2'b00, res_nxt, 2'b01};
        if (r2 >= trial) begin
          r2      = r2 - trial;
          res_nxt = {res_nxt[14:0], 1'b1};
        end else begin
          res_nxt = {res_nxt[14:0], 1'b0};
        end
        rem_nxt = r2[17:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (en) begin
        vld_r <= sq_vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sat_r <= sq_sat[s];
        rem_r <= rem_nxt;
        res_r <= res_nxt;
        val_r <= val_nxt;
        sb_r  <= sq_sb[s];
      end
    end

    assign sq_vld[s+1] = vld_r;
    assign sq_sat[s+1] = sat_r;
    assign sq_rem[s+1] = rem_r;
    assign sq_res[s+1] = res_r;
    assign sq_val[s+1] = val_r;
    assign sq_sb[s+1]  = sb_r;
  end

  // t = 1 - dist
  logic             t_vld_r;
  logic [Q16_W-1:0] t_r, dist_nxt;
  item_sb_t         t_sb_r;

  assign dist_nxt = sq_sat[SQ_NST] ? ONE_Q16 : {1'b0, sq_res[SQ_NST]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_vld_r <= 1'b0;
    end else if (en) begin
      t_vld_r <= sq_vld[SQ_NST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r    <= ONE_Q16 - dist_nxt;
      t_sb_r <= sq_sb[SQ_NST];
    end
  end

  // curve points and lookup
  logic [Q16_W-1:0] ctime_r [MAX_POINTS];
  logic [Q16_W-1:0] cval_r  [MAX_POINTS];
  logic             load_we;

  assign load_we = en && t_vld_r && (t_sb_r.func == FUNC_LOAD);

  always_ff @(posedge clk) begin
    for (int e = 0; e < MAX_POINTS; e++) begin
      if (load_we && (32'(t_sb_r.idx) == e)) begin
        ctime_r[e] <= t_sb_r.ptime;
        cval_r[e]  <= t_sb_r.pval;
      end
    end
  end

  logic [Q16_W-1:0] v0_nxt, v1_nxt, span_nxt, d_nxt;

  always_comb begin : p_lookup
    int               n;
    logic [Q16_W-1:0] lastt, lastv;
    logic             found;
    logic [Q16_W-1:0] ft0, ft1, fv0, fv1;
    n = (pcount_r == 4'd0) ? 1 : int'(pcount_r);
    if (n > MAX_POINTS) n = MAX_POINTS;
    lastt = ctime_r[0];
    lastv = cval_r[0];
    for (int e = 0; e < MAX_POINTS; e++) begin
      if (e == n - 1) begin
        lastt = ctime_r[e];
        lastv = cval_r[e];
      end
    end
    found = 1'b0;
    ft0 = '0;
    ft1 = '0;
    fv0 = '0;
    fv1 = '0;
    for (int e = MAX_POINTS - 2; e >= 0; e--) begin
      if ((e + 1 < n) && (t_r >= ctime_r[e]) && (t_r < ctime_r[e+1])) begin
        found = 1'b1;
        ft0 = ctime_r[e];
        ft1 = ctime_r[e+1];
        fv0 = cval_r[e];
        fv1 = cval_r[e+1];
      end
    end
    v1_nxt   = '0;
    span_nxt = Q16_W'(1);
    d_nxt    = '0;
    if (t_r < ctime_r[0]) begin
      v0_nxt = cval_r[0];
    end else if (t_r >= lastt) begin
      v0_nxt = lastv;
    end else if (found) begin
      v0_nxt   = fv0;
      v1_nxt   = fv1;
      span_nxt = ft1 - ft0;
      d_nxt    = t_r - ft0;
    end else begin
      v0_nxt = lastv;
    end
  end

  logic             l_vld_r;
  logic [Q16_W-1:0] v0_r, v1_r, span_r, d_r;

  // products, then sum
  logic             p_vld_r, s_vld_r;
  logic [33:0]      p0_r, p1_r;
  logic [Q16_W-1:0] pspan_r, sspan_r;
  logic [34:0]      inum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_vld_r <= 1'b0;
      p_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
    end else if (en) begin
      l_vld_r <= t_vld_r && (t_sb_r.func == FUNC_PIXEL);
      p_vld_r <= l_vld_r;
      s_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v0_r    <= v0_nxt;
      v1_r    <= v1_nxt;
      span_r  <= span_nxt;
      d_r     <= d_nxt;
      p0_r    <= 34'(v0_r) * 34'(span_r - d_r);
      p1_r    <= 34'(v1_r) * 34'(d_r);
      pspan_r <= span_r;
      inum_r  <= 35'(p0_r) + 35'(p1_r);
      sspan_r <= pspan_r;
    end
  end

  logic             iv_vld;
  logic [Q16_W-1:0] iv_q;

  // numerator < 2^17 * span, so its upper part already fits below the span
  rgc_pdiv #(.DEN_W(Q16_W), .Q_W(Q16_W), .SPS(4), .SB_W(1)) u_divi (
    .clk, .rst_n, .en,
    .in_vld(s_vld_r), .in_rem(inum_r[33:17]), .in_bits(inum_r[16:0]), .in_den(sspan_r),
    .in_sb(1'b0),
    .out_vld(iv_vld), .out_quo(iv_q), .out_sb()
  );

  // gray = floor(255 * v / 65536), saturated
  logic [24:0] g255;
  logic [8:0]  ghi;
  logic [7:0]  gray_nxt;

  always_comb begin
    g255     = {iv_q, 8'd0} - 25'(iv_q);
    ghi      = g255[24:16];
    gray_nxt = (ghi > 9'd255) ? 8'd255 : ghi[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= iv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_gray_r <= gray_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_gray_level = out_gray_r;

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    dx_vld == dy_vld) else $error("x and y dividers out of step");

  a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    l_vld_r |-> span_r != '0) else $error("zero interpolation span");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |-> in_stall) else $error("input taken while output stalled");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (en && t_vld_r && t_sb_r.func == FUNC_LOAD) |=> !l_vld_r)
    else $error("load item produced a result");

endmodule

>>> verif/tb.sv
module tb;
  import rgc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = 1'b0;
  logic [2:0] in_point_index = '0;
  logic [Q16_W-1:0] in_point_time = '0;
  logic [Q16_W-1:0] in_point_value = '0;
  logic [11:0] in_pixel_x = '0;
  logic [11:0] in_pixel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_gray_level;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  radial_gradient_curve_pixel_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_point_index(in_point_index), .in_point_time(in_point_time),
    .in_point_value(in_point_value), .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y),
    .out_valid(out_valid), .out_stall(out_stall), .out_gray_level(out_gray_level),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  logic [12:0] img_w, img_h;
  logic [3:0] pt_count;
  logic [Q16_W-1:0] crv_time [8];
  logic [Q16_W-1:0] crv_val [8];
  logic [7:0] gray_expected [$];
  int errors = 0;
  int pixels_sent = 0;
  int loads_sent = 0;
  int grays_seen = 0;
  bit idle_on = 1'b1;
  bit hold_rx = 1'b0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic logic [16:0] axis_dist(input logic [12:0] size, input logic [11:0] pos);
    logic [13:0] twice;
    logic [13:0] num;
    logic [31:0] q;
    twice = {1'b0, pos, 1'b0};
    num = (size >= twice) ? size - twice : twice - size;
    if (size == 0) return ONE_Q16;
    q = ({18'd0, num} << 16) / size;
    return (q > ONE_Q16) ? ONE_Q16 : q[16:0];
  endfunction

  function automatic logic [7:0] pixel_gray(input logic [11:0] x, input logic [11:0] y);
    logic [16:0] dx, dy;
    logic [35:0] sum;
    logic [35:0] root;
    logic [16:0] t, t0, t1;
    logic [63:0] v, gray;
    int n;
    dx = axis_dist(img_w, x);
    dy = axis_dist(img_h, y);
    sum = dx * dx + dy * dy;
    root = 0;
    for (int b = 17; b >= 0; b--)
      if ((root | (36'd1 << b)) * (root | (36'd1 << b)) <= sum) root |= 36'd1 << b;
    if (root > ONE_Q16) root = ONE_Q16;
    t = ONE_Q16 - root[16:0];
    n = (pt_count == 0) ? 1 : (pt_count > 8 ? 8 : pt_count);
    if (t < crv_time[0]) v = crv_val[0];
    else if (t >= crv_time[n-1]) v = crv_val[n-1];
    else begin
      v = crv_val[n-1];
      for (int i = 0; i + 1 < n; i++) begin
        t0 = crv_time[i];
        t1 = crv_time[i+1];
        if (t >= t0 && t < t1) begin
          v = (64'(crv_val[i]) * (t1 - t) + 64'(crv_val[i+1]) * (t - t0)) / (t1 - t0);
          break;
        end
      end
    end
    gray = (v * 255) >> 16;
    return (gray > 255) ? 8'd255 : gray[7:0];
  endfunction

  task automatic send_item(input logic func, input logic [2:0] idx, input logic [16:0] pt,
                           input logic [16:0] pv, input logic [11:0] x, input logic [11:0] y);
    in_valid <= 1'b1;
    in_func <= func;
    in_point_index <= idx;
    in_point_time <= pt;
    in_point_value <= pv;
    in_pixel_x <= x;
    in_pixel_y <= y;
    do @(posedge clk); while (in_stall);
    if (func == FUNC_LOAD) begin
      crv_time[idx] = pt;
      crv_val[idx] = pv;
      loads_sent++;
    end else begin
      gray_expected.push_back(pixel_gray(x, y));
      pixels_sent++;
    end
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic finish_item();
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    finish_item();
    while (gray_expected.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t r, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_WIDTH: img_w = data[12:0];
      REG_HEIGHT: img_h = data[12:0];
      default: pt_count = data[3:0];
    endcase
  endtask

  task automatic load_curve(input int n, input bit ordered);
    logic [16:0] tm;
    tm = 0;
    for (int i = 0; i < 8; i++) begin
      if (ordered) tm = (i == 0) ? 17'($urandom_range(0, 8000))
                                 : 17'(tm + $urandom_range(0, 16000));
      else tm = 17'($urandom_range(0, 65536));
      if (tm > ONE_Q16) tm = ONE_Q16;
      send_item(FUNC_LOAD, 3'(i), tm, ($urandom_range(0, 9) == 0) ? 17'h1ffff :
                17'($urandom_range(0, 65536)), 12'd0, 12'd0);
    end
  endtask

  task automatic rand_pixel();
    send_item(FUNC_PIXEL, 3'($urandom), 17'($urandom), 17'($urandom),
              12'($urandom_range(0, 1) ? $urandom_range(0, 2 * img_w) : $urandom),
              12'($urandom_range(0, 1) ? $urandom_range(0, 2 * img_h) : $urandom));
  endtask

  task automatic test_directed();
    send_item(FUNC_LOAD, 0, 17'd0, 17'd0, 12'hfff, 12'hfff);
    send_item(FUNC_LOAD, 1, ONE_Q16, ONE_Q16, 0, 0);
    send_item(FUNC_PIXEL, 7, 17'h1ffff, 17'h1ffff, 32, 32);
    send_item(FUNC_PIXEL, 0, 0, 0, 0, 0);
    send_item(FUNC_PIXEL, 0, 0, 0, 12'hfff, 12'hfff);
    send_item(FUNC_PIXEL, 0, 0, 0, 0, 32);
    send_item(FUNC_PIXEL, 0, 0, 0, 40, 20);
    send_item(FUNC_LOAD, 0, 17'd20000, 17'h1ffff, 0, 0);
    send_item(FUNC_LOAD, 1, 17'd10000, 17'd30000, 0, 0);
    send_item(FUNC_PIXEL, 0, 0, 0, 32, 32);
    send_item(FUNC_PIXEL, 0, 0, 0, 33, 30);
    send_item(FUNC_PIXEL, 0, 0, 0, 0, 0);
    send_item(FUNC_LOAD, 0, 17'd40000, 17'd1000, 0, 0);
    send_item(FUNC_LOAD, 1, 17'h1ffff, 17'd1000, 0, 0);
    send_item(FUNC_PIXEL, 0, 0, 0, 32, 34);
    drain();
  endtask

  task automatic test_geometry();
    int sizes [6] = '{1, 2, 4096, 8191, 0, 37};
    for (int k = 0; k < 6; k++) begin
      cfg_write(REG_WIDTH, $urandom | sizes[k]);
      cfg_write(REG_HEIGHT, sizes[5 - k]);
      cfg_write(REG_COUNT, $urandom_range(1, 8));
      load_curve(8, 1);
      repeat (40) rand_pixel();
      drain();
    end
  endtask

  task automatic test_counts();
    for (int c = 0; c < 16; c++) begin
      cfg_write(REG_COUNT, c);
      cfg_write(REG_WIDTH, $urandom_range(1, 4096));
      cfg_write(REG_HEIGHT, $urandom_range(1, 4096));
      load_curve(8, c % 3 != 0);
      repeat (10) rand_pixel();
      drain();
    end
  endtask

  task automatic test_backpressure();
    hold_rx = 1'b1;
    repeat (60) rand_pixel();
    hold_rx = 1'b0;
    drain();
  endtask

  task automatic test_random();
    for (int i = 0; i < 150; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(FUNC_LOAD, 3'($urandom), 17'($urandom_range(0, 65536)), 17'($urandom),
                  12'($urandom), 12'($urandom));
      else rand_pixel();
    end
    drain();
    idle_on = 1'b0;
    repeat (120) rand_pixel();
    drain();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (gray_expected.size() == 0) report($sformatf("unexpected gray %0d", out_gray_level));
      else begin
        if (out_gray_level !== gray_expected[0])
          report($sformatf("gray_level got %0d want %0d", out_gray_level, gray_expected[0]));
        void'(gray_expected.pop_front());
      end
      grays_seen++;
    end
  end

  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        out_stall <= 1'b0;
        wait (!hold_rx);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 15);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #4ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    img_w = 64;
    img_h = 64;
    pt_count = 2;
    foreach (crv_time[i]) begin
      crv_time[i] = 0;
      crv_val[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_geometry();
    test_counts();
    test_backpressure();
    test_random();
    $display("covered %0d pixel items and %0d curve loads, %0d gray levels checked,",
             pixels_sent, loads_sent, grays_seen);
    $display("over edge sizes, all point counts, unordered curves and long output stalls");
    if (errors == 0 && gray_expected.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/rgc_pkg.sv
hw/rtl/rgc_pdiv.sv
hw/rtl/radial_gradient_curve_pixel_unit.sv
verif/tb.sv
